/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the damped spring substep filter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DSSF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DSSF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/dssf_pkg.sv */
// ----------------------------------------------------------------------------
// dssf_pkg
// Types and constants shared by the damped spring substep filter modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dssf_pkg;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 31;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DAMP  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT = 2'd2;

   // Stream widths.
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 64;

   // Register widths and values.
   localparam int FREQ_W  = 11;
   localparam int DAMP_W  = 9;
   localparam int LIMIT_W = 31;
   localparam logic [FREQ_W-1:0]  FREQ_MIN   = 11'd256;
   localparam logic [FREQ_W-1:0]  FREQ_MAX   = 11'd1280;
   localparam logic [FREQ_W-1:0]  FREQ_RST   = 11'd512;
   localparam logic [DAMP_W-1:0]  DAMP_MIN   = 9'd102;
   localparam logic [DAMP_W-1:0]  DAMP_MAX   = 9'd256;
   localparam logic [DAMP_W-1:0]  DAMP_RST   = 9'd179;
   localparam logic [LIMIT_W-1:0] LIMIT_RST  = 31'd1966080;

   // Fixed-point datapath.
   localparam int POS_W    = 32;
   localparam int TIME_W   = 16;
   localparam int FRAC_W   = 16;
   localparam int OMEGA_W  = 21;
   localparam int OMEGA2_W = 26;
   localparam int KDAMP_W  = 23;
   localparam int DIFF_W   = 33;
   localparam int TERMA_W  = 44;
   localparam int TERMB_W  = 40;
   localparam int ACC_W    = 45;
   localparam int PSUM_W   = 34;
   localparam logic [18:0] TWO_PI_Q16 = 19'd411775;

   // Controller to datapath commands, one strobe per datapath step.
   typedef struct packed {
      logic load;
      logic prep;
      logic coef;
      logic diff;
      logic mul_ab;
      logic acc;
      logic mul_v;
      logic vel;
      logic mul_p;
      logic pos;
      logic load_rsp;
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic rem_zero;
      logic last_sub;
   } status_type;

endpackage

`default_nettype wire

/* rtl/damped_spring_substep_filter.sv */
// ----------------------------------------------------------------------------
// damped_spring_substep_filter
// Damped spring follower with semi-implicit Euler substeps in Q16.16.
// ----------------------------------------------------------------------------
// Each accepted beat carries a target and an elapsed time; the block advances
// its spring position and velocity toward the clamped target and returns one
// beat with the new position and velocity. The elapsed time is limited to
// MAX_STEP_TICKS and split into substeps of at most SUBSTEP_TICKS, and the
// substeps run one after another through a single shared datapath, each in the
// steps DIFF, MUL_AB, ACC, MUL_V, VEL, MUL_P and POS. The number of substeps
// is 0 for zero elapsed time and up to 13 with the default parameters. One
// update is worked on at a time; the input is ready again once the result has
// moved to the output register, where it waits for the consumer.
`timescale 1ns / 1ps
`default_nettype none

module damped_spring_substep_filter #(
   parameter int SUBSTEP_TICKS  = 546,
   parameter int MAX_STEP_TICKS = 6554
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [dssf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dssf_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // target [31:0], delta_time [47:32]
   input  logic [dssf_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // position [31:0], speed [63:32]
   output logic [dssf_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import dssf_pkg::*;

   cmd_type    cmd;
   status_type status;

   dssf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   dssf_datapath #(
      .SUBSTEP_TICKS  (SUBSTEP_TICKS),
      .MAX_STEP_TICKS (MAX_STEP_TICKS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

endmodule

`default_nettype wire

/* rtl/dssf_ctrl.sv */
// ----------------------------------------------------------------------------
// dssf_ctrl
// Sequencer that steps the datapath through the setup and substep phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dssf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output dssf_pkg::cmd_type    cmd,
   input  dssf_pkg::status_type status
);
   import dssf_pkg::*;

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b000_0000_0001,
      ST_PREP   = 11'b000_0000_0010,
      ST_COEF   = 11'b000_0000_0100,
      ST_DIFF   = 11'b000_0000_1000,
      ST_MUL_AB = 11'b000_0001_0000,
      ST_ACC    = 11'b000_0010_0000,
      ST_MUL_V  = 11'b000_0100_0000,
      ST_VEL    = 11'b000_1000_0000,
      ST_MUL_P  = 11'b001_0000_0000,
      ST_POS    = 11'b010_0000_0000,
      ST_DONE   = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_COEF;
         end
         ST_COEF: begin
            cmd.coef = 1'b1;
            state_in = status.rem_zero ? ST_DONE : ST_DIFF;
         end
         ST_DIFF: begin
            cmd.diff = 1'b1;
            state_in = ST_MUL_AB;
         end
         ST_MUL_AB: begin
            cmd.mul_ab = 1'b1;
            state_in   = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = ST_MUL_V;
         end
         ST_MUL_V: begin
            cmd.mul_v = 1'b1;
            state_in  = ST_VEL;
         end
         ST_VEL: begin
            cmd.vel  = 1'b1;
            state_in = ST_MUL_P;
         end
         ST_MUL_P: begin
            cmd.mul_p = 1'b1;
            state_in  = ST_POS;
         end
         ST_POS: begin
            cmd.pos  = 1'b1;
            state_in = status.last_sub ? ST_DONE : ST_DIFF;
         end
         ST_DONE: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/dssf_datapath.sv */
// ----------------------------------------------------------------------------
// dssf_datapath
// Configuration registers, spring state and the fixed-point arithmetic steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dssf_datapath #(
   parameter int SUBSTEP_TICKS  = 546,
   parameter int MAX_STEP_TICKS = 6554
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [dssf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dssf_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [dssf_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  dssf_pkg::cmd_type                   cmd,
   output dssf_pkg::status_type                status,
   output logic [dssf_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import dssf_pkg::*;

   localparam int DT_W = $clog2(SUBSTEP_TICKS + 1);
   localparam int DV_W = ACC_W + DT_W + 1 - FRAC_W;
   localparam int DP_W = POS_W + DT_W + 1 - FRAC_W;
   localparam logic [TIME_W-1:0] MAX_TICKS = TIME_W'(MAX_STEP_TICKS);
   localparam logic [TIME_W-1:0] SUB_TICKS = TIME_W'(SUBSTEP_TICKS);
   localparam logic signed [DV_W:0] VEL_MAX = {{(DV_W - 30){1'b0}}, {31{1'b1}}};
   localparam logic signed [DV_W:0] VEL_MIN = {{(DV_W - 30){1'b1}}, {31{1'b0}}};

   // Configuration; frequency and damping are stored already clamped.
   logic [FREQ_W-1:0]  freq_ff, freq_in;
   logic [DAMP_W-1:0]  damp_ff, damp_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [11:0]        wr_freq;
   logic [8:0]         wr_damp;

   // Spring state and working registers.
   logic signed [POS_W-1:0]  pos_ff, pos_in;
   logic signed [POS_W-1:0]  vel_ff, vel_in;
   logic signed [POS_W-1:0]  target_ff, target_in;
   logic [TIME_W-1:0]        rem_ff, rem_in;
   logic [DT_W-1:0]          dt_ff, dt_in;
   logic [OMEGA_W-1:0]       omega_ff, omega_in;
   logic [OMEGA2_W-1:0]      omega2_ff, omega2_in;
   logic [KDAMP_W-1:0]       kdamp_ff, kdamp_in;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic signed [TERMA_W-1:0] term_a_ff, term_a_in;
   logic signed [TERMB_W-1:0] term_b_ff, term_b_in;
   logic signed [ACC_W-1:0]  accel_ff, accel_in;
   logic signed [DV_W-1:0]   dv_ff, dv_in;
   logic signed [DP_W-1:0]   dp_ff, dp_in;
   logic [POS_W-1:0]         rsp_pos_ff, rsp_pos_in;
   logic [POS_W-1:0]         rsp_vel_ff, rsp_vel_in;

   // Combinational intermediates.
   logic [TIME_W-1:0]              req_time;
   logic signed [POS_W-1:0]        req_target;
   logic signed [POS_W:0]          tgt_x, lim_x;
   logic signed [POS_W-1:0]        lim_pos, lim_neg;
   logic [29:0]                    omega_prod;
   logic [2*OMEGA_W-1:0]           omega_sq;
   logic [DAMP_W+OMEGA_W-1:0]      kdamp_prod;
   logic signed [OMEGA2_W:0]       omega2_s;
   logic signed [KDAMP_W:0]        kdamp_s;
   logic signed [DT_W:0]           dt_s;
   logic signed [OMEGA2_W+DIFF_W:0] prod_a;
   logic signed [KDAMP_W+POS_W:0]  prod_b;
   logic signed [ACC_W+DT_W:0]     prod_v;
   logic signed [POS_W+DT_W:0]     prod_p;
   logic signed [DV_W:0]           vsum;
   logic signed [PSUM_W-1:0]       psum, plim_pos, plim_neg;

   assign req_target = req_tdata[POS_W-1:0];
   assign req_time   = req_tdata[POS_W+TIME_W-1:POS_W];
   assign wr_freq    = csr_wdata[11:0];
   assign wr_damp    = csr_wdata[8:0];

   assign lim_pos = signed'({1'b0, limit_ff});
   assign lim_neg = -lim_pos;
   assign tgt_x   = (POS_W + 1)'(target_ff);
   assign lim_x   = (POS_W + 1)'(lim_pos);

   assign omega_prod = 30'(freq_ff) * 30'(TWO_PI_Q16);
   assign omega_sq   = (2 * OMEGA_W)'(omega_ff) * (2 * OMEGA_W)'(omega_ff);
   assign kdamp_prod = (DAMP_W + OMEGA_W)'(damp_ff) * (DAMP_W + OMEGA_W)'(omega_ff);

   assign omega2_s = signed'({1'b0, omega2_ff});
   assign kdamp_s  = signed'({1'b0, kdamp_ff});
   assign dt_s     = signed'({1'b0, dt_ff});
   assign prod_a   = omega2_s * diff_ff;
   assign prod_b   = kdamp_s * vel_ff;
   assign prod_v   = accel_ff * dt_s;
   assign prod_p   = vel_ff * dt_s;

   assign vsum     = (DV_W + 1)'(vel_ff) + (DV_W + 1)'(dv_ff);
   assign psum     = PSUM_W'(pos_ff) + PSUM_W'(dp_ff);
   assign plim_pos = PSUM_W'(lim_pos);
   assign plim_neg = PSUM_W'(lim_neg);

   always_comb begin
      freq_in  = freq_ff;
      damp_in  = damp_ff;
      limit_in = limit_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_FREQ: begin
               if (wr_freq < 12'(FREQ_MIN)) begin
                  freq_in = FREQ_MIN;
               end else if (wr_freq > 12'(FREQ_MAX)) begin
                  freq_in = FREQ_MAX;
               end else begin
                  freq_in = wr_freq[FREQ_W-1:0];
               end
            end
            CSR_DAMP: begin
               if (wr_damp < DAMP_MIN) begin
                  damp_in = DAMP_MIN;
               end else if (wr_damp > DAMP_MAX) begin
                  damp_in = DAMP_MAX;
               end else begin
                  damp_in = wr_damp;
               end
            end
            CSR_LIMIT: begin
               limit_in = csr_wdata[LIMIT_W-1:0];
            end
            default: begin
               limit_in = limit_ff;
            end
         endcase
      end
   end

   always_comb begin
      target_in  = target_ff;
      rem_in     = rem_ff;
      dt_in      = dt_ff;
      omega_in   = omega_ff;
      omega2_in  = omega2_ff;
      kdamp_in   = kdamp_ff;
      diff_in    = diff_ff;
      term_a_in  = term_a_ff;
      term_b_in  = term_b_ff;
      accel_in   = accel_ff;
      dv_in      = dv_ff;
      dp_in      = dp_ff;
      pos_in     = pos_ff;
      vel_in     = vel_ff;
      rsp_pos_in = rsp_pos_ff;
      rsp_vel_in = rsp_vel_ff;

      if (cmd.load) begin
         target_in = req_target;
         rem_in    = (req_time > MAX_TICKS) ? MAX_TICKS : req_time;
      end
      if (cmd.prep) begin
         omega_in = omega_prod[28:8];
         if (tgt_x > lim_x) begin
            target_in = lim_pos;
         end else if (tgt_x < -lim_x) begin
            target_in = lim_neg;
         end
      end
      if (cmd.coef) begin
         omega2_in = omega_sq[2*OMEGA_W-1:FRAC_W];
         kdamp_in  = kdamp_prod[DAMP_W+OMEGA_W-1:7];
      end
      if (cmd.diff) begin
         diff_in = DIFF_W'(target_ff) - DIFF_W'(pos_ff);
         dt_in   = (rem_ff < SUB_TICKS) ? rem_ff[DT_W-1:0] : SUB_TICKS[DT_W-1:0];
      end
      if (cmd.mul_ab) begin
         term_a_in = prod_a[OMEGA2_W+DIFF_W:FRAC_W];
         term_b_in = prod_b[KDAMP_W+POS_W:FRAC_W];
      end
      if (cmd.acc) begin
         accel_in = ACC_W'(term_a_ff) - ACC_W'(term_b_ff);
      end
      if (cmd.mul_v) begin
         dv_in = prod_v[ACC_W+DT_W:FRAC_W];
      end
      if (cmd.vel) begin
         if (vsum > VEL_MAX) begin
            vel_in = VEL_MAX[POS_W-1:0];
         end else if (vsum < VEL_MIN) begin
            vel_in = VEL_MIN[POS_W-1:0];
         end else begin
            vel_in = vsum[POS_W-1:0];
         end
      end
      if (cmd.mul_p) begin
         dp_in = prod_p[POS_W+DT_W:FRAC_W];
      end
      if (cmd.pos) begin
         rem_in = rem_ff - TIME_W'(dt_ff);
         if (psum > plim_pos) begin
            pos_in = lim_pos;
            vel_in = '0;
         end else if (psum < plim_neg) begin
            pos_in = lim_neg;
            vel_in = '0;
         end else begin
            pos_in = psum[POS_W-1:0];
         end
      end
      if (cmd.load_rsp) begin
         rsp_pos_in = pos_ff;
         rsp_vel_in = vel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff  <= FREQ_RST;
         damp_ff  <= DAMP_RST;
         limit_ff <= LIMIT_RST;
         pos_ff   <= '0;
         vel_ff   <= '0;
      end else begin
         freq_ff  <= freq_in;
         damp_ff  <= damp_in;
         limit_ff <= limit_in;
         pos_ff   <= pos_in;
         vel_ff   <= vel_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff  <= target_in;
      rem_ff     <= rem_in;
      dt_ff      <= dt_in;
      omega_ff   <= omega_in;
      omega2_ff  <= omega2_in;
      kdamp_ff   <= kdamp_in;
      diff_ff    <= diff_in;
      term_a_ff  <= term_a_in;
      term_b_ff  <= term_b_in;
      accel_ff   <= accel_in;
      dv_ff      <= dv_in;
      dp_ff      <= dp_in;
      rsp_pos_ff <= rsp_pos_in;
      rsp_vel_ff <= rsp_vel_in;
   end

   assign status.rem_zero = (rem_ff == '0);
   assign status.last_sub = (rem_ff == TIME_W'(dt_ff));
   assign rsp_tdata       = {rsp_vel_ff, rsp_pos_ff};

endmodule

`default_nettype wire

/* rtl/dssf_checker.sv */
// ----------------------------------------------------------------------------
// dssf_checker
// Port-level checks on the damped spring substep filter, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dssf_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [dssf_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import dssf_pkg::*;

   logic       req_beat;
   logic       rsp_beat;
   logic [1:0] pend_ff, pend_in;

   assign req_beat = req_tvalid && req_tready;
   assign rsp_beat = rsp_tvalid && rsp_tready;

   // Updates accepted but not yet delivered.
   always_comb begin
      pend_in = pend_ff;
      if (req_beat && !rsp_beat) begin
         pend_in = pend_ff + 2'd1;
      end else if (rsp_beat && !req_beat) begin
         pend_in = pend_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `DSSF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result beat changed while stalled")
   `DSSF_ASSERT_NEXT(a_single_update, clock, reset, req_beat, !req_tready, "input ready right after an accepted beat")
   `DSSF_ASSERT_SAME(a_rsp_has_source, clock, reset, rsp_tvalid, pend_ff != 2'd0, "result beat without an accepted update")
   `DSSF_ASSERT_SAME(a_ready_room, clock, reset, req_tready, pend_ff == 2'd0 || pend_ff == 2'd1, "input ready with two updates pending")

endmodule

bind damped_spring_substep_filter dssf_checker u_dssf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
